[sv/mssq_pkg.sv]
`default_nettype none

package mssq_pkg;

    localparam int TABLE_STEPS_DEF = 16;
    localparam int QDEPTH          = 4;
    localparam int QPTR_W          = $clog2(QDEPTH);
    localparam int QCNT_W          = $clog2(QDEPTH + 1);
    localparam int POSX_W          = 5;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 7;

    localparam logic [6:0] VEL_FULL  = 7'd127;
    localparam logic [6:0] NOTE_MAX  = 7'd127;
    localparam logic [6:0] NOTE_BASE = 7'd36;
    localparam logic [6:0] NOTE_STEP = 7'd3;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_START  = 3'd1,
        OP_CONT   = 3'd2,
        OP_STOP   = 3'd3,
        OP_WRITE  = 3'd4,
        OP_SETPOS = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        CFG_TPS      = 3'd0,
        CFG_STEPS    = 3'd1,
        CFG_FIRST    = 3'd2,
        CFG_LAST     = 3'd3,
        CFG_BACKWARD = 3'd4,
        CFG_REPEAT   = 3'd5,
        CFG_CHANNEL  = 3'd6,
        CFG_MASK     = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_OFF = 2'd0,
        EV_ON  = 2'd1,
        EV_CB  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [6:0] ticks_per_step;
        logic [4:0] step_count;
        logic [3:0] first_step;
        logic [3:0] last_step;
        logic       play_backward;
        logic       repeat_mode;
        logic [3:0] midi_channel;
        logic [1:0] send_mask;
    } t_cfg;

    typedef struct packed {
        logic       cb;
        logic [1:0] mask;
        logic [3:0] chan;
        logic [6:0] off_note;
        logic [6:0] on_note;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    function automatic logic [6:0] note_init(input logic [POSX_W-1:0] idx);
        note_init = NOTE_BASE + 7'(idx) * NOTE_STEP;
    endfunction

endpackage

`default_nettype wire

[sv/mssq_front.sv]
`default_nettype none

module mssq_front #(
    parameter int TABLE_STEPS = mssq_pkg::TABLE_STEPS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mssq_pkg::t_cfg             i_cfg,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [2:0]                 i_op,
    input  wire logic [7:0]                 i_step_index,
    input  wire logic signed [8:0]          i_note_value,
    input  wire logic [mssq_pkg::QCNT_W-1:0] i_q_count,
    output mssq_pkg::t_push                 o_push
);
    import mssq_pkg::*;

    localparam int POS_W = $clog2(TABLE_STEPS);

    logic [31:0]      r_gap;
    logic [31:0]      r_nst;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_prev;
    logic             r_halted;
    logic [6:0]       r_mem [TABLE_STEPS];
    logic [TABLE_STEPS-1:0] r_written;

    logic             r_s1_valid;
    logic             r_s1_cb;
    logic [1:0]       r_s1_mask;
    logic [3:0]       r_s1_chan;
    logic [6:0]       r_off_raw;
    logic [6:0]       r_on_raw;
    logic             r_off_wr;
    logic             r_on_wr;
    logic [POS_W-1:0] r_off_addr;
    logic [POS_W-1:0] r_on_addr;

    logic              accept;
    t_op               op;
    logic              idx_ok;
    logic              fire;
    logic              notes;
    logic [31:0]       gap_inc;
    logic [31:0]       addend;
    logic [31:0]       n_gap;
    logic [POSX_W-1:0] steps;
    logic [POSX_W-1:0] end_pos;
    logic [POSX_W-1:0] begin_pos;
    logic [POSX_W-1:0] pos_x;
    logic [POSX_W-1:0] n_pos;
    logic              wrap;
    logic [6:0]        clamp_note;
    logic [POS_W-1:0]  widx;

    assign o_ready = r_s1_valid ? (i_q_count < QCNT_W'(QDEPTH - 1))
                                : (i_q_count < QCNT_W'(QDEPTH));
    assign accept  = i_valid && o_ready;
    assign op      = t_op'(i_op);
    assign idx_ok  = i_step_index < 8'(TABLE_STEPS);
    assign widx    = i_step_index[POS_W-1:0];
    assign notes   = i_cfg.step_count != 5'd0;

    // counter minus step time, plus one, not negative
    assign gap_inc = r_gap + 32'd1;
    assign fire   = (op == OP_TICK) && !r_halted && !gap_inc[31];
    assign addend = fire ? (32'd1 - 32'(i_cfg.ticks_per_step)) : 32'd1;
    assign n_gap  = r_gap + addend;

    // loop bounds
    always_comb begin
        steps     = (i_cfg.step_count < POSX_W'(TABLE_STEPS)) ? i_cfg.step_count
                                                             : POSX_W'(TABLE_STEPS);
        end_pos   = ({1'b0, i_cfg.last_step} < (steps - 5'd1)) ? {1'b0, i_cfg.last_step}
                                                              : (steps - 5'd1);
        begin_pos = ({1'b0, i_cfg.first_step} < end_pos) ? {1'b0, i_cfg.first_step}
                                                         : end_pos;
        pos_x     = POSX_W'(r_pos);
        if (i_cfg.play_backward) begin
            wrap  = pos_x <= begin_pos;
            n_pos = wrap ? end_pos : (pos_x - 5'd1);
        end else begin
            wrap  = pos_x >= end_pos;
            n_pos = wrap ? begin_pos : (pos_x + 5'd1);
        end
    end

    always_comb begin
        if (i_note_value[8]) begin
            clamp_note = 7'd0;
        end else if (i_note_value[7]) begin
            clamp_note = NOTE_MAX;
        end else begin
            clamp_note = i_note_value[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap      <= '0;
            r_nst      <= '0;
            r_pos      <= '0;
            r_prev     <= '0;
            r_halted   <= 1'b1;
            r_written  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept && fire && (!notes || (i_cfg.send_mask != 2'd0));
            if (accept) begin
                case (op)
                    OP_TICK: begin
                        r_gap <= n_gap;
                        if (fire) begin
                            r_nst <= r_nst + 32'(i_cfg.ticks_per_step);
                            if (notes) begin
                                r_pos  <= n_pos[POS_W-1:0];
                                r_prev <= r_pos;
                                if (wrap && !i_cfg.repeat_mode) begin
                                    r_halted <= 1'b1;
                                end
                            end
                        end
                    end
                    OP_START: begin
                        r_gap    <= '0;
                        r_nst    <= '0;
                        r_halted <= 1'b0;
                    end
                    OP_CONT: begin
                        r_gap    <= 32'd0 - r_nst;
                        r_halted <= 1'b0;
                    end
                    OP_STOP: begin
                        r_halted <= 1'b1;
                    end
                    OP_WRITE: begin
                        if (idx_ok) begin
                            r_written[widx] <= 1'b1;
                        end
                    end
                    OP_SETPOS: begin
                        if (idx_ok) begin
                            r_pos <= widx;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // note table and its read ports
    always_ff @(posedge i_clk) begin
        if (accept && (op == OP_WRITE) && idx_ok) begin
            r_mem[widx] <= clamp_note;
        end
        if (accept && fire) begin
            r_off_raw  <= r_mem[r_prev];
            r_on_raw   <= r_mem[r_pos];
            r_off_wr   <= r_written[r_prev];
            r_on_wr    <= r_written[r_pos];
            r_off_addr <= r_prev;
            r_on_addr  <= r_pos;
            r_s1_cb    <= !notes;
            r_s1_mask  <= i_cfg.send_mask;
            r_s1_chan  <= i_cfg.midi_channel;
        end
    end

    always_comb begin
        o_push.valid        = r_s1_valid;
        o_push.cmd.cb       = r_s1_cb;
        o_push.cmd.mask     = r_s1_mask;
        o_push.cmd.chan     = r_s1_chan;
        o_push.cmd.off_note = r_off_wr ? r_off_raw : note_init(POSX_W'(r_off_addr));
        o_push.cmd.on_note  = r_on_wr ? r_on_raw : note_init(POSX_W'(r_on_addr));
    end

endmodule

`default_nettype wire

[sv/mssq_queue.sv]
`default_nettype none

module mssq_queue (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mssq_pkg::t_push             i_push,
    input  wire logic                        i_pop,
    output logic                             o_valid,
    output mssq_pkg::t_cmd                   o_cmd,
    output logic [mssq_pkg::QCNT_W-1:0]      o_count
);
    import mssq_pkg::*;

    t_cmd              r_buf [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_buf[r_rd];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({i_push.valid, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_buf[r_wr] <= i_push.cmd;
        end
    end

endmodule

`default_nettype wire

[sv/mssq_back.sv]
`default_nettype none

module mssq_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire mssq_pkg::t_cmd i_q_cmd,
    output logic                o_q_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [1:0]          o_event_kind,
    output logic                o_destination,
    output logic [3:0]          o_channel,
    output logic [6:0]          o_note,
    output logic [6:0]          o_velocity,
    output logic                o_last_of_run
);
    import mssq_pkg::*;

    logic       r_busy;
    t_cmd       r_cmd;
    logic       r_dest;
    logic       r_phase;
    logic       r_out_valid;
    logic [1:0] r_kind;
    logic       r_out_dest;
    logic [3:0] r_chan;
    logic [6:0] r_note;
    logic [6:0] r_vel;
    logic       r_last;

    logic       can_emit;
    logic       emit;
    logic       last;
    t_kind      kind;

    assign can_emit = !r_out_valid || i_ready;
    assign emit     = r_busy && can_emit;
    assign last     = r_cmd.cb || (r_phase && (r_dest || !r_cmd.mask[1]));
    assign kind     = r_cmd.cb ? EV_CB : (r_phase ? EV_ON : EV_OFF);
    assign o_q_pop  = i_q_valid && (!r_busy || (emit && last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (can_emit) begin
                r_out_valid <= r_busy;
            end
            if (o_q_pop) begin
                r_busy <= 1'b1;
            end else if (emit && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd   <= i_q_cmd;
            r_phase <= 1'b0;
            r_dest  <= !i_q_cmd.mask[0];
        end else if (emit && !last) begin
            if (!r_phase) begin
                r_phase <= 1'b1;
            end else begin
                r_phase <= 1'b0;
                r_dest  <= 1'b1;
            end
        end
        if (emit) begin
            r_kind     <= kind;
            r_out_dest <= r_cmd.cb ? 1'b0 : r_dest;
            r_chan     <= r_cmd.cb ? 4'd0 : r_cmd.chan;
            r_note     <= r_cmd.cb ? 7'd0 : (r_phase ? r_cmd.on_note : r_cmd.off_note);
            r_vel      <= r_cmd.cb ? 7'd0 : VEL_FULL;
            r_last     <= last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_event_kind  = r_kind;
    assign o_destination = r_out_dest;
    assign o_channel     = r_chan;
    assign o_note        = r_note;
    assign o_velocity    = r_vel;
    assign o_last_of_run = r_last;

endmodule

`default_nettype wire

[sv/midi_step_sequencer_track.sv]
`default_nettype none

// One step sequencer track. Input beats (tick, start, continue, stop, note write,
// position set) are taken one per cycle while the queue has room; the front keeps
// the tick timing, play position and a note table in flip-flops with a written bit
// per entry, so entries never written read their power-up note with no clearing
// pass. A tick that fires drops a command into a four-entry queue (none if notes
// are on and the send mask is zero); the back expands it into 1, 2 or 4 result
// beats at one per cycle while the output is not stalled, via an output register,
// so the back expander sets sustained tick throughput. A first result passes the
// front, queue, back and output registers. Other beats give no results.
module midi_step_sequencer_track_unit #(
    parameter int TABLE_STEPS = mssq_pkg::TABLE_STEPS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mssq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mssq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [2:0]                      i_op,
    input  wire logic [7:0]                      i_step_index,
    input  wire logic signed [8:0]               i_note_value,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [1:0]                           o_event_kind,
    output logic                                 o_destination,
    output logic [3:0]                           o_channel,
    output logic [6:0]                           o_note,
    output logic [6:0]                           o_velocity,
    output logic                                 o_last_of_run
);
    import mssq_pkg::*;

    t_cfg              r_cfg;
    t_push             push;
    logic              q_valid;
    t_cmd              q_cmd;
    logic              q_pop;
    logic [QCNT_W-1:0] q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_step <= 7'd6;
            r_cfg.step_count     <= 5'd16;
            r_cfg.first_step     <= 4'd0;
            r_cfg.last_step      <= 4'd15;
            r_cfg.play_backward  <= 1'b0;
            r_cfg.repeat_mode    <= 1'b1;
            r_cfg.midi_channel   <= 4'd0;
            r_cfg.send_mask      <= 2'd3;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_TPS:      r_cfg.ticks_per_step <= i_cfg_data[6:0];
                CFG_STEPS:    r_cfg.step_count     <= i_cfg_data[4:0];
                CFG_FIRST:    r_cfg.first_step     <= i_cfg_data[3:0];
                CFG_LAST:     r_cfg.last_step      <= i_cfg_data[3:0];
                CFG_BACKWARD: r_cfg.play_backward  <= i_cfg_data[0];
                CFG_REPEAT:   r_cfg.repeat_mode    <= i_cfg_data[0];
                CFG_CHANNEL:  r_cfg.midi_channel   <= i_cfg_data[3:0];
                CFG_MASK:     r_cfg.send_mask      <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    mssq_front #(
        .TABLE_STEPS(TABLE_STEPS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_op         (i_op),
        .i_step_index (i_step_index),
        .i_note_value (i_note_value),
        .i_q_count    (q_count),
        .o_push       (push)
    );

    mssq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .o_count (q_count)
    );

    mssq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_cmd),
        .o_q_pop       (q_pop),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_event_kind  (o_event_kind),
        .o_destination (o_destination),
        .o_channel     (o_channel),
        .o_note        (o_note),
        .o_velocity    (o_velocity),
        .o_last_of_run (o_last_of_run)
    );

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QCNT_W'(QDEPTH))
        else $error("command queue overrun");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_count == QCNT_W'(QDEPTH)) |-> !o_in_ready)
        else $error("beat taken with queue full");

    a_cb_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_event_kind == EV_CB)) |-> o_last_of_run)
        else $error("callback pulse not final");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> (q_count < QCNT_W'(QDEPTH)) || q_pop)
        else $error("push into full queue");

endmodule

`default_nettype wire
